### hdl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// shared types and constants for the ray/box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int NUM_AXES = 3;

    typedef logic [2:0] reg_idx_t;

    // register map, index into the register list
    localparam reg_idx_t REG_ORIGIN_X = 3'd0;
    localparam reg_idx_t REG_ORIGIN_Y = 3'd1;
    localparam reg_idx_t REG_ORIGIN_Z = 3'd2;
    localparam reg_idx_t REG_DIR_X    = 3'd3;
    localparam reg_idx_t REG_DIR_Y    = 3'd4;
    localparam reg_idx_t REG_DIR_Z    = 3'd5;
    localparam reg_idx_t REG_MAX_DIST = 3'd6;

    // per-item flags carried alongside the dividers
    typedef struct packed {
        logic       in_box;
        logic [2:0] skip;
    } side_t;

endpackage

### hdl/rbst_cfg.sv
// ----------------------------------------------------------------------------
// rbst_cfg
// apb register bank holding the ray
// ----------------------------------------------------------------------------
module rbst_cfg #(
    parameter int W      = 32,
    parameter int APB_W  = 32,
    parameter int ADDR_W = 5,
    parameter int AL     = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [APB_W-1:0]         pwdata,
    output logic [APB_W-1:0]         prdata,
    output logic signed [W-1:0]      origin [3],
    output logic signed [W-1:0]      dir [3],
    output logic [W-2:0]             tmax
);
    import rbst_pkg::*;

    logic signed [W-1:0] origin_reg [3];
    logic signed [W-1:0] dir_reg [3];
    logic [W-2:0]        tmax_reg;
    reg_idx_t            idx;
    logic                wr;

    assign idx = paddr[AL+2:AL];
    assign wr  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                origin_reg[a] <= '0;
                dir_reg[a]    <= '0;
            end
            tmax_reg <= '1;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ORIGIN_X: origin_reg[0] <= pwdata[W-1:0];
                REG_ORIGIN_Y: origin_reg[1] <= pwdata[W-1:0];
                REG_ORIGIN_Z: origin_reg[2] <= pwdata[W-1:0];
                REG_DIR_X:    dir_reg[0]    <= pwdata[W-1:0];
                REG_DIR_Y:    dir_reg[1]    <= pwdata[W-1:0];
                REG_DIR_Z:    dir_reg[2]    <= pwdata[W-1:0];
                REG_MAX_DIST: tmax_reg      <= pwdata[W-2:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ORIGIN_X: prdata = APB_W'(origin_reg[0]);
            REG_ORIGIN_Y: prdata = APB_W'(origin_reg[1]);
            REG_ORIGIN_Z: prdata = APB_W'(origin_reg[2]);
            REG_DIR_X:    prdata = APB_W'(dir_reg[0]);
            REG_DIR_Y:    prdata = APB_W'(dir_reg[1]);
            REG_DIR_Z:    prdata = APB_W'(dir_reg[2]);
            REG_MAX_DIST: prdata = APB_W'(tmax_reg);
            default:      prdata = '0;
        endcase
    end

    assign origin = origin_reg;
    assign dir    = dir_reg;
    assign tmax   = tmax_reg;

endmodule

### hdl/rbst_div.sv
// ----------------------------------------------------------------------------
// rbst_div
// pipelined saturating fixed-point divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbst_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W+F:0]         num_mag,
    input  logic [W-1:0]         den_mag,
    input  logic                 neg,
    output logic signed [W-1:0]  q
);
    localparam int NW = W + 1 + F;
    localparam logic [W:0] NEG_LIM = (W+1)'(1) << (W-1);
    localparam logic [W:0] POS_LIM = NEG_LIM - (W+1)'(1);

    logic [W-1:0]  rem_reg [W+2];
    logic [W:0]    quo_reg [W+2];
    logic [NW-1:0] num_reg [W+2];
    logic [W-1:0]  den_reg [W+2];
    logic          neg_reg [W+2];
    logic          ovf_reg [W+2];
    logic signed [W-1:0] q_reg;

    logic [NW-1:0] hi;
    assign hi = num_mag >> (W+1);

    // pre stage: quotient too large for w+1 bits saturates anyway
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= hi >= NW'(den_mag);
            rem_reg[0] <= hi[W-1:0];
            quo_reg[0] <= '0;
            num_reg[0] <= num_mag;
            den_reg[0] <= den_mag;
            neg_reg[0] <= neg;
        end
    end

    for (genvar s = 1; s <= W+1; s++)
    begin : g_step
        logic [W:0] trial;
        logic       ge;
        assign trial = {rem_reg[s-1], num_reg[s-1][W+1-s]};
        assign ge    = trial >= {1'b0, den_reg[s-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? W'(trial - {1'b0, den_reg[s-1]}) : trial[W-1:0];
                quo_reg[s] <= {quo_reg[s-1][W-1:0], ge};
                num_reg[s] <= num_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
        end
    end

    logic [W:0] qf;
    assign qf = quo_reg[W+1];

    // sign and saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_reg[W+1])
            begin
                if (ovf_reg[W+1] || qf > NEG_LIM)
                    q_reg <= -$signed(NEG_LIM[W-1:0]);
                else
                    q_reg <= -$signed(qf[W-1:0]);
            end
            else
            begin
                if (ovf_reg[W+1] || qf > POS_LIM)
                    q_reg <= $signed(POS_LIM[W-1:0]);
                else
                    q_reg <= $signed(qf[W-1:0]);
            end
        end
    end

    assign q = q_reg;

endmodule

### hdl/ray_box_slab_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test
// streaming ray versus axis-aligned box slab test
// ----------------------------------------------------------------------------
// usage:
//   the ray (origin, direction, maximum distance) is written over the apb
//   port while the block is idle; all registers read back
//   boxes arrive on the s_ channel, one item per cycle while s_tready is high, and
//   each gives one hit flag on the m_ channel, in order
//   each item passes the capture and difference stages, the six bit-per-stage
//   dividers, one quotient bit each stage, the fold stages and the output register;
//   throughput is one item per clock while the output is not stalled
//   the whole pipeline moves on one advance enable: when the output register
//   holds an item that m_tready does not take, every stage holds and
//   s_tready falls, so nothing is lost or repeated
//   reset clears all valid bits and loads the registers with a zero ray and
//   the largest maximum distance
// ----------------------------------------------------------------------------
module ray_box_slab_test #(
    parameter int  COORD_BITS = 32,
    parameter int  FRAC_BITS  = 16,
    localparam int APB_W      = (COORD_BITS > 32) ? 64 : 32,
    localparam int AL         = (COORD_BITS > 32) ? 3 : 2,
    localparam int ADDR_W     = AL + 3,
    localparam int TD_W       = ((6*COORD_BITS + 7) / 8) * 8
) (
    input  logic clk,
    input  logic rst_n,
    // apb configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_W-1:0]       pwdata,
    output logic [APB_W-1:0]       prdata,
    output logic                   pready,
    // box items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [TD_W-1:0]        s_tdata,
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit, then zero fill
    output logic [7:0]             m_tdata
);
    import rbst_pkg::*;

    localparam int W       = COORD_BITS;
    localparam int F       = FRAC_BITS;
    localparam int DIV_LAT = W + 3;

    logic signed [W-1:0] origin [3];
    logic signed [W-1:0] dir [3];
    logic [W-2:0]        tmax;

    assign pready = 1'b1;

    rbst_cfg #(.W(W), .APB_W(APB_W), .ADDR_W(ADDR_W), .AL(AL)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .origin  (origin),
        .dir     (dir),
        .tmax    (tmax)
    );

    // global advance: the output register frees up or is empty
    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // ---- stage 1: capture the box ----
    logic                v1_reg;
    logic signed [W-1:0] lo1_reg [3];
    logic signed [W-1:0] hi1_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                lo1_reg[a] <= s_tdata[a*W +: W];
                hi1_reg[a] <= s_tdata[(a+3)*W +: W];
            end
        end
    end

    // ---- stage 2: exact differences, magnitudes, signs, containment test ----
    logic signed [W:0] dlo [3];
    logic signed [W:0] dhi [3];
    logic [W:0]        mlo [3];
    logic [W:0]        mhi [3];
    logic [W-1:0]      mden [3];
    logic              in_box;

    always_comb
    begin
        in_box = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dlo[a]  = $signed({lo1_reg[a][W-1], lo1_reg[a]}) -
                      $signed({origin[a][W-1], origin[a]});
            dhi[a]  = $signed({hi1_reg[a][W-1], hi1_reg[a]}) -
                      $signed({origin[a][W-1], origin[a]});
            mlo[a]  = dlo[a][W] ? (W+1)'(0) - dlo[a] : dlo[a];
            mhi[a]  = dhi[a][W] ? (W+1)'(0) - dhi[a] : dhi[a];
            mden[a] = dir[a][W-1] ? W'(0) - dir[a] : dir[a];
            // origin outside the slab on this axis
            if (origin[a] < lo1_reg[a] || origin[a] > hi1_reg[a])
                in_box = 1'b0;
        end
    end

    logic         v2_reg;
    logic [W+F:0] nlo2_reg [3];
    logic [W+F:0] nhi2_reg [3];
    logic [W-1:0] den2_reg [3];
    logic         sl2_reg [3];
    logic         sh2_reg [3];
    side_t        side2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                nlo2_reg[a]        <= {mlo[a], F'(0)};
                nhi2_reg[a]        <= {mhi[a], F'(0)};
                den2_reg[a]        <= mden[a];
                sl2_reg[a]         <= dlo[a][W] ^ dir[a][W-1];
                sh2_reg[a]         <= dhi[a][W] ^ dir[a][W-1];
                side2_reg.skip[a]  <= (dir[a] == '0);
            end
            side2_reg.in_box <= in_box;
        end
    end

    // ---- divider stages: six plane distances ----
    logic signed [W-1:0] tlo [3];
    logic signed [W-1:0] thi [3];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        rbst_div #(.W(W), .F(F)) u_div_lo (
            .clk     (clk),
            .en      (adv),
            .num_mag (nlo2_reg[a]),
            .den_mag (den2_reg[a]),
            .neg     (sl2_reg[a]),
            .q       (tlo[a])
        );
        rbst_div #(.W(W), .F(F)) u_div_hi (
            .clk     (clk),
            .en      (adv),
            .num_mag (nhi2_reg[a]),
            .den_mag (den2_reg[a]),
            .neg     (sh2_reg[a]),
            .q       (thi[a])
        );
    end

    // flags ride alongside the dividers
    side_t sd_reg [DIV_LAT];
    logic  vd_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= side2_reg;
            for (int k = 1; k < DIV_LAT; k++)
                sd_reg[k] <= sd_reg[k-1];
        end
    end

    // ---- fold stage 1: order each pair ----
    logic                vf1_reg;
    logic signed [W-1:0] tn1_reg [3];
    logic signed [W-1:0] tx1_reg [3];
    side_t               sf1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (tlo[a] > thi[a])
                begin
                    tn1_reg[a] <= thi[a];
                    tx1_reg[a] <= tlo[a];
                end
                else
                begin
                    tn1_reg[a] <= tlo[a];
                    tx1_reg[a] <= thi[a];
                end
            end
            sf1_reg <= sd_reg[DIV_LAT-1];
        end
    end

    // ---- fold stage 2: entry by max, exit by min ----
    logic signed [W-1:0] tpos;
    logic signed [W-1:0] t_enter;
    logic signed [W-1:0] t_exit;

    assign tpos = $signed({1'b0, tmax});

    always_comb
    begin
        t_enter = -tpos;
        t_exit  = tpos;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (!sf1_reg.skip[a])
            begin
                if (tn1_reg[a] > t_enter)
                    t_enter = tn1_reg[a];
                if (tx1_reg[a] < t_exit)
                    t_exit = tx1_reg[a];
            end
        end
    end

    logic                vf2_reg;
    logic signed [W-1:0] ent2_reg;
    logic signed [W-1:0] ext2_reg;
    logic                in2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent2_reg <= t_enter;
            ext2_reg <= t_exit;
            in2_reg  <= sf1_reg.in_box;
        end
    end

    // ---- output register ----
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            hit_reg <= in2_reg || (ent2_reg <= ext2_reg && ext2_reg <= tpos);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
                vd_reg[k] <= 1'b0;
            vf1_reg       <= 1'b0;
            vf2_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int k = 1; k < DIV_LAT; k++)
                vd_reg[k] <= vd_reg[k-1];
            vf1_reg       <= vd_reg[DIV_LAT-1];
            vf2_reg       <= vf1_reg;
            out_valid_reg <= vf2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, hit_reg};

endmodule
